>>> hdl/dre_pkg.sv
// Shared widths, constants and controller/datapath types for the rate estimator.
package dre_pkg;

  localparam int SIZE_W     = 32;
  localparam int TICK_W     = 32;
  localparam int OBS_W      = 32;
  localparam int RATE_W     = 48;
  localparam int BYTE_TOT_W = 48;
  localparam int TICK_TOT_W = 40;
  localparam int Q_FRAC     = 16;
  localparam int WEIGHT_W   = Q_FRAC + 1;
  localparam int WNUM_W     = 6;
  localparam int WDEN_W     = 7;

  localparam logic [OBS_W-1:0]    OBS_RESET  = OBS_W'(250000);
  localparam logic [WEIGHT_W-1:0] Q_ONE      = WEIGHT_W'(65536);
  localparam logic [WEIGHT_W-1:0] Q_HALF     = WEIGHT_W'(32768);
  localparam logic [WNUM_W-1:0]   WEIGHT_NUM = WNUM_W'(33);
  localparam logic [WDEN_W-1:0]   WEIGHT_DEN = WDEN_W'(100);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic mul_start;
    logic mul_step;
    logic rdiv_start;
    logic wdiv_start;
    logic div_step;
    logic ring_upd;
    logic scan_step;
    logic blend_start;
    logic blend_step;
    logic commit;
    logic out_load;
    logic out_closed;
  } dre_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic zero_ticks;
    logic reached;
    logic mul_last;
    logic div_last;
    logic scan_last;
    logic blend_last;
    logic sum_zero;
  } dre_sts_t;

endpackage

>>> hdl/dre_if.sv
// Handshake channel interfaces for report beats and estimate beats.
interface dre_rpt_if;
  import dre_pkg::*;
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] size_bytes;
  logic [TICK_W-1:0] elapsed_ticks;
  modport source (output valid, output size_bytes, output elapsed_ticks, input ready);
  modport sink (input valid, input size_bytes, input elapsed_ticks, output ready);
endinterface

interface dre_est_if;
  import dre_pkg::*;
  logic              valid;
  logic              ready;
  logic              window_closed;
  logic [RATE_W-1:0] measured_bps;
  logic [RATE_W-1:0] average_bps;
  logic [RATE_W-1:0] usable_bps;
  modport source (output valid, output window_closed, output measured_bps,
                  output average_bps, output usable_bps, input ready);
  modport sink (input valid, input window_closed, input measured_bps,
                input average_bps, input usable_bps, output ready);
endinterface

>>> hdl/dre_ctrl.sv
// Controller state machine sequencing the estimator datapath.
module dre_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  dre_pkg::dre_sts_t sts,
  output dre_pkg::dre_cmd_t cmd
);
  import dre_pkg::*;

  typedef enum logic [3:0] {
    IDLE, CHECK, MUL, RLOAD, RDIV, RING, SCAN, WLOAD, WDIV, WSET, BLEND,
    COMMIT, FINISH
  } state_t;

  state_t state, state_next;
  logic   closed, closed_next;
  logic   out_free;

  assign in_ready = (state == IDLE);
  assign out_free = !out_valid || out_ready;

  // Next state and commands
  always_comb begin
    state_next  = state;
    closed_next = closed;
    cmd         = '0;
    cmd.out_closed = closed;
    case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = CHECK;
        end
      end
      CHECK: begin
        if (sts.zero_ticks || !sts.reached) begin
          closed_next = 1'b0;
          state_next  = FINISH;
        end else begin
          closed_next   = 1'b1;
          cmd.mul_start = 1'b1;
          state_next    = MUL;
        end
      end
      MUL: begin
        cmd.mul_step = 1'b1;
        if (sts.mul_last) state_next = RLOAD;
      end
      RLOAD: begin
        cmd.rdiv_start = 1'b1;
        state_next     = RDIV;
      end
      RDIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = RING;
      end
      RING: begin
        cmd.ring_upd = 1'b1;
        state_next   = SCAN;
      end
      SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_next = WLOAD;
      end
      WLOAD: begin
        cmd.wdiv_start = 1'b1;
        state_next     = sts.sum_zero ? WSET : WDIV;
      end
      WDIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = WSET;
      end
      WSET: begin
        cmd.blend_start = 1'b1;
        state_next      = BLEND;
      end
      BLEND: begin
        cmd.blend_step = 1'b1;
        if (sts.blend_last) state_next = COMMIT;
      end
      COMMIT: begin
        cmd.commit = 1'b1;
        state_next = FINISH;
      end
      FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  // Hold state and the output beat flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      closed    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      closed <= closed_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

>>> hdl/dre_dp.sv
// Datapath: accumulators, shift-add multiplier, shared divider, rate rings, blend.
module dre_dp #(
  parameter int WINDOW_SLOTS     = 10,
  parameter int TICKS_PER_SECOND = 1000000
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [dre_pkg::OBS_W-1:0]  cfg_wr_data,
  input  logic [dre_pkg::SIZE_W-1:0] size_bytes,
  input  logic [dre_pkg::TICK_W-1:0] elapsed_ticks,
  input  dre_pkg::dre_cmd_t          cmd,
  output dre_pkg::dre_sts_t          sts,
  output logic                       window_closed,
  output logic [dre_pkg::RATE_W-1:0] measured_bps,
  output logic [dre_pkg::RATE_W-1:0] average_bps,
  output logic [dre_pkg::RATE_W-1:0] usable_bps
);
  import dre_pkg::*;

  localparam longint K     = longint'(TICKS_PER_SECOND) * 8;
  localparam int     KW    = $clog2(K + 1);
  localparam int     PW    = BYTE_TOT_W + KW;
  localparam int     SW    = RATE_W + $clog2(WINDOW_SLOTS);
  localparam int     NW    = RATE_W + WNUM_W + Q_FRAC;
  localparam int     DDW   = (PW > NW) ? PW : NW;
  localparam int     DSW   = SW + WDEN_W;
  localparam int     DVW   = (DSW > TICK_TOT_W) ? DSW : TICK_TOT_W;
  localparam int     CW    = $clog2(DDW + 1);
  localparam int     PIW   = $clog2(WINDOW_SLOTS);
  localparam int     KIW   = (KW > 1) ? $clog2(KW) : 1;
  localparam int     WIW   = $clog2(WEIGHT_W);
  localparam int     AW    = RATE_W + Q_FRAC;
  localparam logic [KW-1:0] KC = KW'(K);

  logic [OBS_W-1:0]      obs;
  logic [BYTE_TOT_W-1:0] byte_total;
  logic [TICK_TOT_W-1:0] tick_total;
  logic                  zero_flag;
  logic [PW-1:0]         prod, mcand;
  logic [DDW-1:0]        dvd;
  logic [DVW-1:0]        dvs, rem;
  logic [RATE_W-1:0]     quo;
  logic                  over;
  logic [RATE_W-1:0]     rate, last_rate, smoothed;
  logic [RATE_W-1:0]     rate_ring [WINDOW_SLOTS];
  logic [RATE_W-1:0]     change_ring [WINDOW_SLOTS];
  logic [PIW-1:0]        ptr;
  logic [RATE_W-1:0]     hi_rate, lo_rate;
  logic [SW-1:0]         sum;
  logic [WEIGHT_W-1:0]   weight, cweight;
  logic [AW-1:0]         bacc, ma, mb;
  logic [CW-1:0]         cnt;

  logic [BYTE_TOT_W:0]   bsum;
  logic [TICK_TOT_W:0]   tsum;
  logic [DVW:0]          r2, rdiff;
  logic                  ge;
  logic [RATE_W-1:0]     rate_q, rd, cd, diff;
  logic [WEIGHT_W-1:0]   wq;
  logic [PIW-1:0]        ptr_next;
  logic [NW-1:0]         wnum;
  logic [DSW-1:0]        wden;
  logic [RATE_W+1:0]     u3;
  logic [RATE_W-1:0]     span;

  function automatic logic [WEIGHT_W-1:0] sum_sel_weight(input logic zero,
                                                         input logic [WEIGHT_W-1:0] q);
    return zero ? Q_HALF : q;
  endfunction

  // Saturating accumulate
  assign bsum = (BYTE_TOT_W+1)'(byte_total) + (BYTE_TOT_W+1)'(size_bytes);
  assign tsum = (TICK_TOT_W+1)'(tick_total) + (TICK_TOT_W+1)'(elapsed_ticks);

  // One restoring divide step
  assign r2    = {rem, dvd[DDW-1]};
  assign ge    = r2 >= {1'b0, dvs};
  assign rdiff = r2 - {1'b0, dvs};

  assign rate_q = over ? {RATE_W{1'b1}} : quo;
  assign wq     = (over || quo > RATE_W'(Q_ONE)) ? Q_ONE : quo[WEIGHT_W-1:0];

  assign ptr_next = (ptr == PIW'(WINDOW_SLOTS - 1)) ? '0 : ptr + 1'b1;
  assign diff     = (rate_q >= last_rate) ? rate_q - last_rate : last_rate - rate_q;
  assign rd       = rate_ring[cnt[PIW-1:0]];
  assign cd       = change_ring[cnt[PIW-1:0]];
  assign span     = hi_rate - lo_rate;
  assign wnum     = {(RATE_W+WNUM_W)'(span) * (RATE_W+WNUM_W)'(WEIGHT_NUM), {Q_FRAC{1'b0}}};
  assign wden     = DSW'(sum) * DSW'(WEIGHT_DEN);
  assign u3       = (RATE_W+2)'(smoothed) + {1'b0, smoothed, 1'b0};

  // Status
  assign sts.zero_ticks = zero_flag;
  assign sts.reached    = tick_total >= TICK_TOT_W'(obs);
  assign sts.mul_last   = cnt == CW'(KW - 1);
  assign sts.div_last   = cnt == CW'(DDW - 1);
  assign sts.scan_last  = cnt == CW'(WINDOW_SLOTS - 1);
  assign sts.blend_last = cnt == CW'(WEIGHT_W - 1);
  assign sts.sum_zero   = (sum == '0);

  // Estimator state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      obs        <= OBS_RESET;
      byte_total <= '0;
      tick_total <= '0;
      ptr        <= '0;
      last_rate  <= '0;
      smoothed   <= '0;
      for (int i = 0; i < WINDOW_SLOTS; i++) begin
        rate_ring[i]   <= '0;
        change_ring[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) obs <= cfg_wr_data;
      if (cmd.accept && elapsed_ticks != '0) begin
        byte_total <= bsum[BYTE_TOT_W] ? {BYTE_TOT_W{1'b1}} : bsum[BYTE_TOT_W-1:0];
        tick_total <= tsum[TICK_TOT_W] ? {TICK_TOT_W{1'b1}} : tsum[TICK_TOT_W-1:0];
      end
      // Place the new rate: fill every slot while the ring is empty
      if (cmd.ring_upd) begin
        if (rate_ring[0] == '0) begin
          for (int i = 0; i < WINDOW_SLOTS; i++) rate_ring[i] <= rate_q;
        end else begin
          ptr                   <= ptr_next;
          rate_ring[ptr_next]   <= rate_q;
          change_ring[ptr_next] <= diff;
        end
      end
      if (cmd.commit) begin
        smoothed   <= bacc[Q_FRAC +: RATE_W];
        last_rate  <= rate;
        byte_total <= '0;
        tick_total <= '0;
      end
    end
  end

  // Working registers of the sequenced arithmetic
  always_ff @(posedge clk) begin
    if (cmd.accept) zero_flag <= (elapsed_ticks == '0);
    if (cmd.mul_start || cmd.rdiv_start || cmd.wdiv_start || cmd.ring_upd ||
        cmd.blend_start) begin
      cnt <= '0;
    end else if (cmd.mul_step || cmd.div_step || cmd.scan_step || cmd.blend_step) begin
      cnt <= cnt + 1'b1;
    end
    // Shift-add multiply by the bit-rate constant
    if (cmd.mul_start) begin
      prod  <= '0;
      mcand <= PW'(byte_total);
    end else if (cmd.mul_step) begin
      if (KC[cnt[KIW-1:0]]) prod <= prod + mcand;
      mcand <= {mcand[PW-2:0], 1'b0};
    end
    // Shared divider
    if (cmd.rdiv_start || cmd.wdiv_start) begin
      rem  <= '0;
      quo  <= '0;
      over <= 1'b0;
      dvd  <= cmd.rdiv_start ? DDW'(prod) : DDW'(wnum);
      dvs  <= cmd.rdiv_start ? DVW'(tick_total) : DVW'(wden);
    end else if (cmd.div_step) begin
      rem  <= ge ? rdiff[DVW-1:0] : r2[DVW-1:0];
      quo  <= {quo[RATE_W-2:0], ge};
      over <= over | quo[RATE_W-1];
      dvd  <= {dvd[DDW-2:0], 1'b0};
    end
    // Ring scan for span and change sum
    if (cmd.ring_upd) begin
      rate    <= rate_q;
      hi_rate <= '0;
      lo_rate <= {RATE_W{1'b1}};
      sum     <= '0;
    end else if (cmd.scan_step) begin
      if (rd > hi_rate) hi_rate <= rd;
      if (rd < lo_rate) lo_rate <= rd;
      sum <= sum + SW'(cd);
    end
    // Weighted blend of the old average and the new rate
    if (cmd.blend_start) begin
      weight  <= sum_sel_weight(sts.sum_zero, wq);
      cweight <= Q_ONE - sum_sel_weight(sts.sum_zero, wq);
      bacc    <= '0;
      ma      <= AW'(smoothed);
      mb      <= AW'(rate);
    end else if (cmd.blend_step) begin
      bacc <= bacc + (weight[cnt[WIW-1:0]] ? ma : '0) + (cweight[cnt[WIW-1:0]] ? mb : '0);
      ma   <= {ma[AW-2:0], 1'b0};
      mb   <= {mb[AW-2:0], 1'b0};
    end
    // Output beat
    if (cmd.out_load) begin
      window_closed <= cmd.out_closed;
      measured_bps  <= last_rate;
      average_bps   <= smoothed;
      usable_bps    <= u3[RATE_W+1:2];
    end
  end

endmodule

>>> hdl/download_rate_estimator_top.sv
// Top level of the download rate estimator.
//
//  channel  direction  beat contents
//  rpt      in         size_bytes, elapsed_ticks
//  est      out        window_closed, measured_bps, average_bps, usable_bps
//  cfg      in         observation_ticks (write only)
//
// A report that does not close a window passes through CHECK and FINISH
// before its result is loaded. A closing report runs the shift-add multiply,
// the rate divide, the ring update and scan, the weight divide and the blend;
// the weight divide is skipped when the change sum is zero. The shared
// bit-serial divider, run twice, has a dividend width of 71 at the defaults.
// One report is in work at a time; a new report is taken while
// the last result waits.
// Reset is synchronous and clears all estimator state; a stalled result
// holds the block in its final state until taken.
module download_rate_estimator_top #(
  parameter int WINDOW_SLOTS     = 10,
  parameter int TICKS_PER_SECOND = 1000000
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [dre_pkg::OBS_W-1:0] cfg_wr_data,
  dre_rpt_if.sink                   rpt,
  dre_est_if.source                 est
);
  import dre_pkg::*;

  dre_cmd_t cmd;
  dre_sts_t sts;
  logic     in_ready;
  logic     out_valid;

  assign rpt.ready = in_ready;
  assign est.valid = out_valid;

  dre_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rpt.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (est.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dre_dp #(
    .WINDOW_SLOTS     (WINDOW_SLOTS),
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .size_bytes    (rpt.size_bytes),
    .elapsed_ticks (rpt.elapsed_ticks),
    .cmd           (cmd),
    .sts           (sts),
    .window_closed (est.window_closed),
    .measured_bps  (est.measured_bps),
    .average_bps   (est.average_bps),
    .usable_bps    (est.usable_bps)
  );

endmodule

>>> hdl/dre_chk.sv
// Port-level checker for the rate estimator and its bind.
module dre_chk (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [dre_pkg::RATE_W-1:0] average_bps,
  input logic [dre_pkg::RATE_W-1:0] usable_bps
);
  import dre_pkg::*;

  // Result beat holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // Usable rate is three quarters of the average
  a_usable: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> usable_bps == RATE_W'(((RATE_W+2)'(average_bps) * 3) >> 2))
    else $error("usable rate mismatch");

  // One report in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second report taken while busy");

  // No result beat straight after reset
  a_rst_quiet: assert property (@(posedge clk)
    $past(rst) && !rst |-> !out_valid)
    else $error("result beat after reset");

endmodule

bind download_rate_estimator_top dre_chk u_dre_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (rpt.valid),
  .in_ready    (rpt.ready),
  .out_valid   (est.valid),
  .out_ready   (est.ready),
  .average_bps (est.average_bps),
  .usable_bps  (est.usable_bps)
);
